// ===== hdl/cardsh_pkg.sv =====
// Shared types and constants for the card shuffle dealer.
// Holds the command codes, the sequencer states and the fixed field widths.
// No dependencies; every other file except the remainder unit imports this package.
package cardsh_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned RAND_W = 8;
  localparam int unsigned CARD_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_SWAP    = 2'd1,
    CMD_DEAL    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WR_I,
    ST_WR_J,
    ST_DEAL_RD,
    ST_RESP
  } state_e;

endpackage

// ===== hdl/cardsh_if.sv =====
// Handshake interfaces for the command and result channels.
// Each carries valid, ready and the payload fields.
// Depends on cardsh_pkg for the field widths.
interface cardsh_cmd_if;
  import cardsh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [RAND_W-1:0] rand_byte;

  modport source (output valid, output command, output rand_byte, input ready);
  modport sink   (input valid, input command, input rand_byte, output ready);
endinterface

interface cardsh_res_if;
  import cardsh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card;
  logic              card_valid;
  logic              deck_exhausted;
  logic              shuffle_done;

  modport source (output valid, output card, output card_valid, output deck_exhausted,
                  output shuffle_done, input ready);
  modport sink   (input valid, input card, input card_valid, input deck_exhausted,
                  input shuffle_done, output ready);
endinterface

// ===== hdl/card_shuffle_dealer.sv =====
// Card shuffle dealer: Fisher-Yates shuffle and dealing over a deck store.
// Restart and no-op commands go straight to the result stage, a deal reads the store first, and a
// swap step runs the one-bit-per-cycle remainder unit over RAND_BITS (at most 8) bits while
// entry i is read, then reads entry j and writes both entries back, one access per cycle.
// One command is in work at a time; a finished result waits in the output register.
// Reset (asynchronous, active low) restores identity order, no pending shuffle.
module card_shuffle_dealer #(
  parameter int unsigned DECK_ENTRIES = 52,
  parameter int unsigned RAND_BITS    = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cardsh_cmd_if.sink   cmd_i,
  cardsh_res_if.source res_o
);
  import cardsh_pkg::*;

  // Address width of the store, width of the deal position (which counts up to
  // the deck size itself), and the random bits that actually reach the divider.
  localparam int unsigned ADDR_W = $clog2(DECK_ENTRIES);
  localparam int unsigned POS_W  = $clog2(DECK_ENTRIES + 1);
  localparam int unsigned RB     = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;

  localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(DECK_ENTRIES - 1);
  localparam logic [POS_W-1:0]  CARD_COUNT = POS_W'(DECK_ENTRIES);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] swap_idx_q, swap_idx_d;
  logic [POS_W-1:0]  deal_pos_q, deal_pos_d;
  logic [CARD_W-1:0] held_q, held_d;

  // Result being assembled for the command in work.
  logic [CARD_W-1:0] res_card_q, res_card_d;
  logic              res_cv_q, res_cv_d;
  logic              res_exh_q, res_exh_d;

  // Output register toward the result channel.
  logic              out_valid_q, out_valid_d;
  logic [CARD_W-1:0] out_card_q, out_card_d;
  logic              out_cv_q, out_cv_d;
  logic              out_exh_q, out_exh_d;
  logic              out_done_q, out_done_d;

  logic              cmd_ready;
  logic              mod_start;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;
  logic [POS_W-1:0]  divisor;

  logic              mem_clear;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CARD_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CARD_W-1:0] wr_data;

  // The swap partner is the random value modulo (swap index + 1).
  assign divisor = POS_W'(swap_idx_q) + 1'b1;

  cardsh_mod_unit #(
    .DIVIDEND_W (RB),
    .DIVISOR_W  (POS_W),
    .REM_W      (ADDR_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cmd_i.rand_byte[RB-1:0]),
    .divisor_i  (divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  cardsh_deck_mem #(
    .ENTRIES (DECK_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_deck (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (mem_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Sequencer. A swap reads entry i while the remainder unit runs, then reads
  // entry j once the remainder is known, and writes both entries back, entry i
  // first and then entry j. Only one store access is in flight at a time, so no
  // forwarding is needed: the read data register holds entry i until j is read.
  always_comb begin
    state_d     = state_q;
    swap_idx_d  = swap_idx_q;
    deal_pos_d  = deal_pos_q;
    held_d      = held_q;
    res_card_d  = res_card_q;
    res_cv_d    = res_cv_q;
    res_exh_d   = res_exh_q;
    out_valid_d = out_valid_q;
    out_card_d  = out_card_q;
    out_cv_d    = out_cv_q;
    out_exh_d   = out_exh_q;
    out_done_d  = out_done_q;
    cmd_ready   = 1'b0;
    mod_start   = 1'b0;
    mem_clear   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    // A result taken by the sink frees the output register.
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_i.valid) begin
          res_card_d = '0;
          res_cv_d   = 1'b0;
          res_exh_d  = 1'b0;
          state_d    = ST_RESP;
          case (cmd_e'(cmd_i.command))
            CMD_RESTART: begin
              mem_clear  = 1'b1;
              swap_idx_d = LAST_IDX;
              deal_pos_d = '0;
            end
            CMD_SWAP: begin
              // With no shuffle pending the swap leaves everything as it is.
              if (swap_idx_q != '0) begin
                mod_start = 1'b1;
                rd_en     = 1'b1;
                rd_addr   = swap_idx_q;
                state_d   = ST_DIV;
              end
            end
            CMD_DEAL: begin
              if (deal_pos_q < CARD_COUNT) begin
                rd_en   = 1'b1;
                rd_addr = deal_pos_q[ADDR_W-1:0];
                state_d = ST_DEAL_RD;
              end else begin
                res_exh_d = 1'b1;
              end
            end
            default: begin
              // The unused command code does nothing.
            end
          endcase
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          held_d  = rd_data;
          rd_en   = 1'b1;
          rd_addr = mod_rem;
          state_d = ST_WR_I;
        end
      end
      ST_WR_I: begin
        wr_en   = 1'b1;
        wr_addr = swap_idx_q;
        wr_data = rd_data;
        state_d = ST_WR_J;
      end
      ST_WR_J: begin
        wr_en      = 1'b1;
        wr_addr    = mod_rem;
        wr_data    = held_q;
        swap_idx_d = swap_idx_q - 1'b1;
        state_d    = ST_RESP;
      end
      ST_DEAL_RD: begin
        res_card_d = rd_data;
        res_cv_d   = 1'b1;
        deal_pos_d = deal_pos_q + 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_card_d  = res_card_q;
          out_cv_d    = res_cv_q;
          out_exh_d   = res_exh_q;
          out_done_d  = (swap_idx_q == '0);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      swap_idx_q  <= '0;
      deal_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swap_idx_q  <= swap_idx_d;
      deal_pos_q  <= deal_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    res_card_q <= res_card_d;
    res_cv_q   <= res_cv_d;
    res_exh_q  <= res_exh_d;
    out_card_q <= out_card_d;
    out_cv_q   <= out_cv_d;
    out_exh_q  <= out_exh_d;
    out_done_q <= out_done_d;
  end

  assign cmd_i.ready          = cmd_ready;
  assign res_o.valid          = out_valid_q;
  assign res_o.card           = out_card_q;
  assign res_o.card_valid     = out_cv_q;
  assign res_o.deck_exhausted = out_exh_q;
  assign res_o.shuffle_done   = out_done_q;

endmodule

// ===== hdl/cardsh_mod_unit.sv =====
// Iterative remainder unit: one restoring compare-and-subtract step per cycle.
// Computes dividend modulo divisor for the swap index selection.
// Depends on nothing but its parameters.
module cardsh_mod_unit #(
  parameter int unsigned DIVIDEND_W = 8,
  parameter int unsigned DIVISOR_W  = 6,
  parameter int unsigned REM_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [REM_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_d;

  // The partial remainder stays below the divisor, so one subtract restores it.
  always_comb begin
    shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, div_q};
    if (shifted >= {1'b0, div_q}) begin
      rem_d = diff[DIVISOR_W-1:0];
    end else begin
      rem_d = shifted[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[REM_W-1:0];

endmodule

// ===== hdl/cardsh_deck_mem.sv =====
// Deck store: one write port and one registered read port.
// Per-entry valid bits make an unwritten entry read as its own index.
// Depends on cardsh_pkg for the card width.
module cardsh_deck_mem #(
  parameter int unsigned ENTRIES = 52,
  parameter int unsigned ADDR_W  = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output logic [cardsh_pkg::CARD_W-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [cardsh_pkg::CARD_W-1:0] wr_data_i
);
  import cardsh_pkg::*;

  logic [CARD_W-1:0] deck_mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [CARD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      deck_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // An entry never written since the last restart holds the identity value.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (valid_q[rd_addr_i]) begin
        rd_data_q <= deck_mem_q[rd_addr_i];
      end else begin
        rd_data_q <= CARD_W'(rd_addr_i);
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for card_shuffle_dealer: Fisher-Yates swaps, deals and restarts.
// Depends on cardsh_pkg, on the cardsh_cmd_if and cardsh_res_if interfaces, and on the
// card_shuffle_dealer top level; the expected results come from a model of the deck kept here.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cardsh_pkg::*;

  localparam int unsigned DECK_ENTRIES = 52;
  localparam int unsigned RAND_BITS    = 8;

  // The command field is two bits wide, and the package leaves the fourth code unnamed.
  // The block must treat it as a no-op, so it gets a name here.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // Least number of commands to send; the random part stops once this many are queued.
  localparam int unsigned ITEM_TARGET = 1950;
  // Even a swap step together with a sender gap and a receiver stall leaves no quiet
  // stretch in a correct run near this limit. It also covers a possible clearing pass
  // over the store after reset.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to wait after the last expected result, to catch any stray transaction.
  localparam int unsigned DRAIN_CYCLES   = 32;
  // Idling stops for the final stretch of commands.
  localparam int unsigned CALM_TAIL      = 150;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [RAND_W-1:0] rnd;
  } deck_cmd_t;

  typedef struct {
    logic [CARD_W-1:0] card;
    logic              card_valid;
    logic              deck_exhausted;
    logic              shuffle_done;
  } card_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cardsh_cmd_if cmd_if ();
  cardsh_res_if res_if ();

  card_shuffle_dealer #(
    .DECK_ENTRIES(DECK_ENTRIES),
    .RAND_BITS   (RAND_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Commands still to be driven, and results the deck model says must come back.
  deck_cmd_t    pending_cmds[$];
  card_result_t expected_cards[$];

  // Shadow copy of the deck. All 64 slots are kept so that an index never falls outside.
  logic [CARD_W-1:0] deck_model[64];
  logic [CARD_W-1:0] swap_pos;
  logic [CARD_W:0]   deal_pos;

  int unsigned cmds_total;
  int unsigned cmds_accepted;
  int unsigned error_count;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned quiet_cycles;
  deck_cmd_t    next_cmd;
  card_result_t oldest_card;

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void fill_identity();
    for (int k = 0; k < 64; k++) begin
      deck_model[k] = CARD_W'(k);
    end
  endfunction

  // Applies one accepted command to the deck model and queues the result it must produce.
  function automatic void predict_card(input logic [CMD_W-1:0] op, input logic [RAND_W-1:0] rnd);
    card_result_t      res;
    int unsigned       i;
    int unsigned       j;
    int unsigned       r;
    logic [CARD_W-1:0] held;
    res = '{card: '0, card_valid: 1'b0, deck_exhausted: 1'b0, shuffle_done: 1'b0};
    case (op)
      CMD_RESTART: begin
        fill_identity();
        swap_pos = CARD_W'(DECK_ENTRIES - 1);
        deal_pos = '0;
      end
      CMD_SWAP: begin
        // With no shuffle pending, a swap leaves everything as it is.
        if (swap_pos != '0) begin
          i = swap_pos;
          r = int'(rnd) & ((1 << RAND_BITS) - 1);
          j = r % (i + 1);
          held          = deck_model[i];
          deck_model[i] = deck_model[j];
          deck_model[j] = held;
          swap_pos      = swap_pos - 1'b1;
        end
      end
      CMD_DEAL: begin
        // Once the deck is dealt out, the block flags it and does not reshuffle.
        if (deal_pos >= DECK_ENTRIES) begin
          res.deck_exhausted = 1'b1;
        end else begin
          res.card       = deck_model[deal_pos[CARD_W-1:0]];
          res.card_valid = 1'b1;
          deal_pos       = deal_pos + 1'b1;
        end
      end
      default: begin
        // The unused code only reports the shuffle status.
      end
    endcase
    res.shuffle_done = (swap_pos == '0);
    expected_cards.push_back(res);
  endfunction

  function automatic void push_cmd(input logic [CMD_W-1:0] op, input logic [RAND_W-1:0] rnd);
    deck_cmd_t c;
    c.op  = op;
    c.rnd = rnd;
    pending_cmds.push_back(c);
  endfunction

  // Random byte with extra weight on the two extremes.
  function automatic logic [RAND_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RAND_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Both sides idle in bursts, but not in some stretches and never near the end.
  function automatic bit idling_allowed();
    return (cmds_total - cmds_accepted > CALM_TAIL) && (cmds_accepted % 400 < 280);
  endfunction

  // Command driver. It also feeds the deck model with each accepted transaction,
  // sampled at the same edge at which the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.command   <= CMD_RESTART;
      cmd_if.rand_byte <= '0;
      send_gap         = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_card(cmd_if.command, cmd_if.rand_byte);
        cmds_accepted <= cmds_accepted + 1;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.command   <= next_cmd.op;
          cmd_if.rand_byte <= next_cmd.rnd;
          // A gap, if any, starts once this transaction has been taken.
          if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 7);
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation,
  // and stalls the result channel in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_cards.size() == 0) begin
          flag_error($sformatf("result with nothing expected (card %0d)", res_if.card));
        end else begin
          oldest_card = expected_cards.pop_front();
          if (res_if.card !== oldest_card.card) begin
            flag_error($sformatf("card: got %0d, want %0d", res_if.card, oldest_card.card));
          end
          if (res_if.card_valid !== oldest_card.card_valid) begin
            flag_error($sformatf("card_valid: got %b, want %b",
                                 res_if.card_valid, oldest_card.card_valid));
          end
          if (res_if.deck_exhausted !== oldest_card.deck_exhausted) begin
            flag_error($sformatf("deck_exhausted: got %b, want %b",
                                 res_if.deck_exhausted, oldest_card.deck_exhausted));
          end
          if (res_if.shuffle_done !== oldest_card.shuffle_done) begin
            flag_error($sformatf("shuffle_done: got %b, want %b",
                                 res_if.shuffle_done, oldest_card.shuffle_done));
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 5) == 0) begin
          recv_stall = $urandom_range(1, 7);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned n_swaps;
    int unsigned n_deals;
    int unsigned n_noise;

    rst_ni           = 1'b0;
    cmds_accepted    = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    fill_identity();
    swap_pos = '0;
    deal_pos = '0;

    // Directed part. Right after reset the deck is in identity order with no shuffle
    // pending: deals return 0 and 1, and a swap changes nothing.
    push_cmd(CMD_DEAL, 8'h00);
    push_cmd(CMD_DEAL, 8'hFF);
    push_cmd(CMD_SWAP, 8'hFF);
    push_cmd(CMD_NOP, 8'hAA);
    // Restart arms the shuffle. Then come swaps with the extreme random values,
    // a swap of an entry with itself (r equal to the index), and deals and a no-op
    // in the middle of the shuffle.
    push_cmd(CMD_RESTART, 8'h55);
    push_cmd(CMD_SWAP, 8'hFF);
    push_cmd(CMD_SWAP, 8'h00);
    push_cmd(CMD_SWAP, 8'd49);
    push_cmd(CMD_DEAL, 8'h0F);
    push_cmd(CMD_NOP, 8'h55);
    push_cmd(CMD_SWAP, 8'd48);
    push_cmd(CMD_DEAL, 8'hF0);
    push_cmd(CMD_SWAP, 8'h80);
    push_cmd(CMD_DEAL, 8'h01);
    push_cmd(CMD_RESTART, 8'hFF);
    push_cmd(CMD_DEAL, 8'h00);
    push_cmd(CMD_NOP, 8'hFF);

    // Random part. Most of it is whole rounds: a restart, a full shuffle, then deals
    // running past the end of the deck. Some rounds are cut short or overrun with swaps,
    // some carry stray commands, and short bursts of pure noise fall between them.
    while (pending_cmds.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        push_cmd(CMD_RESTART, random_byte());
        n_swaps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : DECK_ENTRIES - 1;
        for (int k = 0; k < n_swaps; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            push_cmd(CMD_W'($urandom_range(0, 3)), random_byte());
          end
          push_cmd(CMD_SWAP, random_byte());
        end
        n_deals = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DECK_ENTRIES)
                                              : DECK_ENTRIES + $urandom_range(0, 4);
        for (int k = 0; k < n_deals; k++) begin
          push_cmd(CMD_DEAL, random_byte());
        end
      end else begin
        n_noise = $urandom_range(1, 20);
        for (int k = 0; k < n_noise; k++) begin
          push_cmd(CMD_W'($urandom_range(0, 3)), random_byte());
        end
      end
    end
    cmds_total = pending_cmds.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_accepted != cmds_total || expected_cards.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_cards.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_cards.size()));
    end
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
